[src/ow_rpd_pkg.sv]
package ow_rpd_pkg;

  // Command codes carried in the func field of an input word.
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_ABORT = 2'd2;

  // Final status codes.
  localparam logic [1:0] STATUS_PRESENT  = 2'd0;
  localparam logic [1:0] STATUS_ABSENT   = 2'd1;
  localparam logic [1:0] STATUS_LINE_ERR = 2'd2;
  localparam logic [1:0] STATUS_ABORTED  = 2'd3;

  // Configuration register indexes.
  localparam logic [2:0] REG_RESET_LOW  = 3'd0;
  localparam logic [2:0] REG_LISTEN     = 3'd1;
  localparam logic [2:0] REG_MIN_DELAY  = 3'd2;
  localparam logic [2:0] REG_MAX_DELAY  = 3'd3;
  localparam logic [2:0] REG_MIN_WIDTH  = 3'd4;
  localparam logic [2:0] REG_MAX_WIDTH  = 3'd5;
  localparam logic [2:0] REG_ATTEMPTS   = 3'd6;
  localparam logic [2:0] REG_RETRY_GAP  = 3'd7;

  // Register values after reset.
  localparam logic [9:0]  RESET_LOW_DEFAULT = 10'd500;
  localparam logic [11:0] LISTEN_DEFAULT    = 12'd1000;
  localparam logic [9:0]  MIN_DELAY_DEFAULT = 10'd10;
  localparam logic [9:0]  MAX_DELAY_DEFAULT = 10'd100;
  localparam logic [9:0]  MIN_WIDTH_DEFAULT = 10'd40;
  localparam logic [9:0]  MAX_WIDTH_DEFAULT = 10'd300;
  localparam logic [2:0]  ATTEMPTS_DEFAULT  = 3'd3;
  localparam logic [19:0] RETRY_GAP_DEFAULT = 20'd500000;

  // Sequencer phases.
  typedef enum logic [4:0] {
    PH_IDLE   = 5'b00001,
    PH_CHECK  = 5'b00010,
    PH_LOW    = 5'b00100,
    PH_LISTEN = 5'b01000,
    PH_GAP    = 5'b10000
  } phase_t;

  // Input word.
  typedef struct packed {
    logic [1:0] func;
    logic       line_level;
  } cmd_t;

  // Result word.
  typedef struct packed {
    logic       drive_low;
    logic       report_valid;
    logic [2:0] attempt_number;
    logic       low_confirmed;
    logic       presence_found;
    logic [5:0] level_count;
    logic       done_res;
    logic [1:0] status;
  } res_t;

endpackage

[src/onewire_reset_presence_detector_core.sv]
// Latency: the result word for an input word is valid in the cycle after it is accepted.
// Throughput: one word per cycle; the sequencer state and the result register are
// updated in the same single pass, so only a stalled, full result register holds input.
// Reset: synchronous, active high; clears the sequencer to idle and loads the
// configuration registers with their default values.
module onewire_reset_presence_detector_core #(
  parameter int MAX_LEVELS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cmd_valid,
  output logic               cmd_stall,
  input  ow_rpd_pkg::cmd_t   cmd,
  output logic               res_valid,
  input  logic               res_stall,
  output ow_rpd_pkg::res_t   res,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [19:0]        cfg_data
);
  import ow_rpd_pkg::*;

  localparam int LW = $clog2(MAX_LEVELS + 1);

  // Configuration registers.
  logic [9:0]  reset_low_ticks;
  logic [11:0] listen_ticks;
  logic [9:0]  min_delay_ticks;
  logic [9:0]  max_delay_ticks;
  logic [9:0]  min_width_ticks;
  logic [9:0]  max_width_ticks;
  logic [2:0]  max_attempts;
  logic [19:0] retry_gap_ticks;

  // Sequencer state.
  phase_t      phase, phase_next;
  logic [19:0] tick_count, tick_count_next;
  logic [2:0]  attempt_count, attempt_count_next;
  logic [LW-1:0] levels_seen, levels_seen_next;
  logic        previous_level, previous_level_next;
  logic [11:0] fall_time, fall_time_next;
  logic        fall_delay_ok, fall_delay_ok_next;
  logic        attempt_presence, attempt_presence_next;
  logic        low_seen, low_seen_next;
  logic        any_presence, any_presence_next;

  res_t        res_next;
  logic        accept;
  logic        lvl;
  logic [19:0] tick_inc;
  logic [19:0] width;
  logic [20:0] tick_plus;
  logic        found;

  // The result register is the only buffer; input waits only when it is full and held.
  assign cmd_stall = res_valid && res_stall;
  assign accept    = cmd_valid && !cmd_stall;
  assign cfg_ready = 1'b1;

  assign lvl       = cmd.line_level;
  assign tick_inc  = tick_count + 20'd1;
  assign tick_plus = {1'b0, tick_count} + 21'd1;
  assign width     = tick_count - {8'd0, fall_time};

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      reset_low_ticks <= RESET_LOW_DEFAULT;
      listen_ticks    <= LISTEN_DEFAULT;
      min_delay_ticks <= MIN_DELAY_DEFAULT;
      max_delay_ticks <= MAX_DELAY_DEFAULT;
      min_width_ticks <= MIN_WIDTH_DEFAULT;
      max_width_ticks <= MAX_WIDTH_DEFAULT;
      max_attempts    <= ATTEMPTS_DEFAULT;
      retry_gap_ticks <= RETRY_GAP_DEFAULT;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_RESET_LOW: reset_low_ticks <= cfg_data[9:0];
        REG_LISTEN:    listen_ticks    <= cfg_data[11:0];
        REG_MIN_DELAY: min_delay_ticks <= cfg_data[9:0];
        REG_MAX_DELAY: max_delay_ticks <= cfg_data[9:0];
        REG_MIN_WIDTH: min_width_ticks <= cfg_data[9:0];
        REG_MAX_WIDTH: max_width_ticks <= cfg_data[9:0];
        REG_ATTEMPTS:  max_attempts    <= cfg_data[2:0];
        REG_RETRY_GAP: retry_gap_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next state and result word for the word on the input.
  always_comb begin
    phase_next            = phase;
    tick_count_next       = tick_count;
    attempt_count_next    = attempt_count;
    levels_seen_next      = levels_seen;
    previous_level_next   = previous_level;
    fall_time_next        = fall_time;
    fall_delay_ok_next    = fall_delay_ok;
    attempt_presence_next = attempt_presence;
    low_seen_next         = low_seen;
    any_presence_next     = any_presence;
    res_next              = '0;
    found                 = 1'b0;

    unique case (cmd.func)
      FUNC_START: begin
        if (phase == PH_IDLE) begin
          attempt_count_next = 3'd0;
          any_presence_next  = 1'b0;
          tick_count_next    = 20'd0;
          phase_next         = PH_CHECK;
        end
      end
      FUNC_ABORT: begin
        if (phase != PH_IDLE) begin
          phase_next        = PH_IDLE;
          res_next.done_res = 1'b1;
          res_next.status   = STATUS_ABORTED;
        end
      end
      FUNC_TICK: begin
        unique case (phase)
          PH_CHECK: begin
            // The idle line must read high before a reset pulse is sent.
            if (!lvl) begin
              phase_next        = PH_IDLE;
              res_next.done_res = 1'b1;
              res_next.status   = STATUS_LINE_ERR;
            end else begin
              attempt_count_next = attempt_count + 3'd1;
              tick_count_next    = 20'd0;
              phase_next         = PH_LOW;
            end
          end
          PH_LOW: begin
            // The last tick of the pulse samples the confirmation and releases.
            tick_count_next = tick_inc;
            if (tick_inc >= {10'd0, reset_low_ticks}) begin
              low_seen_next    = !lvl;
              tick_count_next  = 20'd0;
              levels_seen_next = '0;
              phase_next       = PH_LISTEN;
            end
          end
          PH_LISTEN: begin
            // Record the release level, then watch edges for the presence pulse.
            if (levels_seen == '0) begin
              previous_level_next   = lvl;
              levels_seen_next      = LW'(1);
              fall_delay_ok_next    = 1'b0;
              attempt_presence_next = 1'b0;
            end else if (lvl != previous_level) begin
              if (!lvl) begin
                fall_time_next     = tick_count[11:0];
                fall_delay_ok_next = (tick_count >= {10'd0, min_delay_ticks}) &&
                                     (tick_count <= {10'd0, max_delay_ticks});
              end else if (fall_delay_ok) begin
                if ((tick_count >= {8'd0, fall_time}) &&
                    (width >= {10'd0, min_width_ticks}) &&
                    (width <= {10'd0, max_width_ticks})) begin
                  attempt_presence_next = 1'b1;
                end
                fall_delay_ok_next = 1'b0;
              end
              levels_seen_next    = levels_seen + LW'(1);
              previous_level_next = lvl;
            end

            if ((tick_plus < {9'd0, listen_ticks}) &&
                (levels_seen_next < LW'(MAX_LEVELS))) begin
              tick_count_next = tick_inc;
            end else begin
              // End of the window: report this attempt.
              found = attempt_presence_next && low_seen;
              if (found) begin
                any_presence_next = 1'b1;
              end
              res_next.report_valid   = 1'b1;
              res_next.attempt_number = attempt_count;
              res_next.low_confirmed  = low_seen;
              res_next.presence_found = found;
              res_next.level_count    = 6'(levels_seen_next);
              if (!low_seen) begin
                phase_next        = PH_IDLE;
                res_next.done_res = 1'b1;
                res_next.status   = STATUS_LINE_ERR;
              end else if (attempt_count >= max_attempts) begin
                phase_next        = PH_IDLE;
                res_next.done_res = 1'b1;
                res_next.status   = (any_presence || found) ? STATUS_PRESENT : STATUS_ABSENT;
              end else begin
                tick_count_next = 20'd0;
                phase_next      = (retry_gap_ticks == 20'd0) ? PH_CHECK : PH_GAP;
              end
            end
          end
          PH_GAP: begin
            tick_count_next = tick_inc;
            if (tick_inc >= retry_gap_ticks) begin
              tick_count_next = 20'd0;
              phase_next      = PH_CHECK;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase

    res_next.drive_low = (phase_next == PH_LOW);
  end

  // Sequencer state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      tick_count       <= 20'd0;
      attempt_count    <= 3'd0;
      levels_seen      <= '0;
      previous_level   <= 1'b1;
      fall_time        <= 12'd0;
      fall_delay_ok    <= 1'b0;
      attempt_presence <= 1'b0;
      low_seen         <= 1'b0;
      any_presence     <= 1'b0;
    end else if (accept) begin
      phase            <= phase_next;
      tick_count       <= tick_count_next;
      attempt_count    <= attempt_count_next;
      levels_seen      <= levels_seen_next;
      previous_level   <= previous_level_next;
      fall_time        <= fall_time_next;
      fall_delay_ok    <= fall_delay_ok_next;
      attempt_presence <= attempt_presence_next;
      low_seen         <= low_seen_next;
      any_presence     <= any_presence_next;
    end
  end

  // Result register: one result word for every accepted input word.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res <= res_next;
    end
  end

endmodule

[test/tb_onewire_reset_presence_detector_core.sv]
module tb_onewire_reset_presence_detector_core;
  import ow_rpd_pkg::*;

  // The unused command code, which the sequencer must ignore.
  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  // Levels recorded per listen window before the window is cut short.
  localparam int LEVEL_CAP = 32;
  // Cycles with no handshake at all before the run is declared hung.
  localparam int STALL_LIMIT = 3000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cmd_valid = 1'b0;
  logic        cmd_stall;
  cmd_t        cmd = '0;
  logic        res_valid;
  logic        res_stall = 1'b0;
  res_t        res;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [19:0] cfg_data = '0;

  onewire_reset_presence_detector_core DUT (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Timing registers as the sequencer sees them, masked to their widths.
  logic [19:0] reg_val [8] = '{20'(RESET_LOW_DEFAULT), 20'(LISTEN_DEFAULT),
                               20'(MIN_DELAY_DEFAULT), 20'(MAX_DELAY_DEFAULT),
                               20'(MIN_WIDTH_DEFAULT), 20'(MAX_WIDTH_DEFAULT),
                               20'(ATTEMPTS_DEFAULT), 20'(RETRY_GAP_DEFAULT)};

  // Shadow copy of the sequencer state.
  phase_t      seq_phase = PH_IDLE;
  logic [19:0] tick_ctr = '0;
  logic [2:0]  attempt_ctr = '0;
  logic [5:0]  level_ctr = '0;
  logic        last_level = 1'b1;
  logic [11:0] fall_at = '0;
  logic        fall_in_window = 1'b0;
  logic        pulse_ok = 1'b0;
  logic        reset_held = 1'b0;
  logic        seq_presence = 1'b0;

  cmd_t pending_cmds [$];
  res_t expected_res [$];
  int   mismatches = 0;
  int   words_checked = 0;
  int   seq_items = 0;
  logic quiet = 1'b0;
  int   send_pause = 0;
  int   recv_pause = 0;
  int   hold_left = 0;
  logic hold_done = 1'b0;
  int   no_progress = 0;

  // Advances the shadow sequencer by one command word and returns the result word.
  function automatic res_t sequencer_step(cmd_t c);
    res_t        r;
    int unsigned t;
    int unsigned w;
    r = '0;
    case (c.func)
      FUNC_START: begin
        if (seq_phase == PH_IDLE) begin
          attempt_ctr = '0;
          seq_presence = 1'b0;
          tick_ctr = '0;
          seq_phase = PH_CHECK;
        end
      end
      FUNC_ABORT: begin
        if (seq_phase != PH_IDLE) begin
          seq_phase = PH_IDLE;
          r.done_res = 1'b1;
          r.status = STATUS_ABORTED;
        end
      end
      FUNC_TICK: begin
        case (seq_phase)
          PH_CHECK: begin
            if (!c.line_level) begin
              seq_phase = PH_IDLE;
              r.done_res = 1'b1;
              r.status = STATUS_LINE_ERR;
            end else begin
              attempt_ctr = attempt_ctr + 3'd1;
              tick_ctr = '0;
              seq_phase = PH_LOW;
            end
          end
          PH_LOW: begin
            tick_ctr = tick_ctr + 20'd1;
            if (tick_ctr >= reg_val[REG_RESET_LOW]) begin
              reset_held = !c.line_level;
              tick_ctr = '0;
              level_ctr = '0;
              seq_phase = PH_LISTEN;
            end
          end
          PH_LISTEN: begin
            t = 32'(tick_ctr);
            // The first tick after release only records the released level.
            if (level_ctr == 0) begin
              last_level = c.line_level;
              level_ctr = 6'd1;
              fall_in_window = 1'b0;
              pulse_ok = 1'b0;
            end else if (c.line_level != last_level) begin
              if (!c.line_level) begin
                fall_at = t[11:0];
                fall_in_window = (t >= reg_val[REG_MIN_DELAY]) &&
                                 (t <= reg_val[REG_MAX_DELAY]);
              end else if (fall_in_window) begin
                w = t - 32'(fall_at);
                if (t >= fall_at && w >= reg_val[REG_MIN_WIDTH] &&
                    w <= reg_val[REG_MAX_WIDTH])
                  pulse_ok = 1'b1;
                fall_in_window = 1'b0;
              end
              level_ctr = level_ctr + 6'd1;
              last_level = c.line_level;
            end
            if (t + 1 < reg_val[REG_LISTEN] && level_ctr < LEVEL_CAP) begin
              tick_ctr = tick_ctr + 20'd1;
            end else begin
              // Window over: report the attempt and decide what comes next.
              if (pulse_ok && reset_held) seq_presence = 1'b1;
              r.report_valid = 1'b1;
              r.attempt_number = attempt_ctr;
              r.low_confirmed = reset_held;
              r.presence_found = pulse_ok && reset_held;
              r.level_count = level_ctr;
              if (!reset_held) begin
                seq_phase = PH_IDLE;
                r.done_res = 1'b1;
                r.status = STATUS_LINE_ERR;
              end else if (attempt_ctr >= reg_val[REG_ATTEMPTS]) begin
                seq_phase = PH_IDLE;
                r.done_res = 1'b1;
                r.status = seq_presence ? STATUS_PRESENT : STATUS_ABSENT;
              end else begin
                tick_ctr = '0;
                seq_phase = (reg_val[REG_RETRY_GAP] == 0) ? PH_CHECK : PH_GAP;
              end
            end
          end
          PH_GAP: begin
            tick_ctr = tick_ctr + 20'd1;
            if (tick_ctr >= reg_val[REG_RETRY_GAP]) begin
              tick_ctr = '0;
              seq_phase = PH_CHECK;
            end
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
    r.drive_low = (seq_phase == PH_LOW);
    return r;
  endfunction

  function automatic cmd_t make_cmd(logic [1:0] f, logic l);
    cmd_t c;
    c.func = f;
    c.line_level = l;
    return c;
  endfunction

  // Sender: presents queued command words, with random pauses between them.
  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      send_pause = 0;
    end else begin
      if (cmd_valid && !cmd_stall) expected_res.push_back(sequencer_step(cmd));
      if (!(cmd_valid && cmd_stall)) begin
        if (send_pause != 0) begin
          send_pause--;
          cmd_valid <= 1'b0;
        end else if (!quiet && $urandom_range(0, 11) == 0) begin
          send_pause = $urandom_range(0, 9);
          cmd_valid <= 1'b0;
        end else if (pending_cmds.size() != 0) begin
          cmd <= pending_cmds.pop_front();
          cmd_valid <= 1'b1;
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver back-pressure: short random bursts, and one long hold once traffic is flowing.
  always @(posedge clk) begin
    if (rst) begin
      res_stall <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      res_stall <= 1'b1;
    end else if (!hold_done && words_checked >= 100) begin
      hold_done <= 1'b1;
      hold_left <= 300;
      res_stall <= 1'b1;
    end else if (recv_pause != 0) begin
      recv_pause <= recv_pause - 1;
      res_stall <= 1'b1;
    end else if (!quiet && $urandom_range(0, 11) == 0) begin
      recv_pause <= $urandom_range(0, 9);
      res_stall <= 1'b1;
    end else begin
      res_stall <= 1'b0;
    end
  end

  task automatic compare_field(string name, logic [5:0] want_v, logic [5:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s expected %0d actual %0d", $time, name, want_v, got_v);
      mismatches++;
    end
  endtask

  // Checks every accepted result word against the oldest expectation.
  always @(posedge clk) begin : result_check
    res_t want;
    if (!rst && res_valid && !res_stall) begin
      if (expected_res.size() == 0) begin
        $display("%0t: unexpected result word, expected none actual %h", $time, res);
        mismatches++;
      end else begin
        want = expected_res.pop_front();
        compare_field("drive_low", 6'(want.drive_low), 6'(res.drive_low));
        compare_field("report_valid", 6'(want.report_valid), 6'(res.report_valid));
        compare_field("attempt_number", 6'(want.attempt_number), 6'(res.attempt_number));
        compare_field("low_confirmed", 6'(want.low_confirmed), 6'(res.low_confirmed));
        compare_field("presence_found", 6'(want.presence_found), 6'(res.presence_found));
        compare_field("level_count", want.level_count, res.level_count);
        compare_field("done_res", 6'(want.done_res), 6'(res.done_res));
        compare_field("status", 6'(want.status), 6'(res.status));
        words_checked++;
      end
    end
  end

  // Ends the run if no handshake completes for too long.
  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (res_valid && !res_stall) ||
        (cfg_valid && cfg_ready)) begin
      no_progress <= 0;
    end else if (no_progress >= STALL_LIMIT) begin
      $display("onewire_reset_presence_detector_core: mismatch");
      $finish;
    end else begin
      no_progress <= no_progress + 1;
    end
  end

  // Writes one timing register, with random bits above its width on the bus.
  task automatic write_reg(logic [2:0] idx, logic [19:0] value);
    int          bits;
    logic [19:0] keep;
    case (idx)
      REG_LISTEN:    bits = 12;
      REG_ATTEMPTS:  bits = 3;
      REG_RETRY_GAP: bits = 20;
      default:       bits = 10;
    endcase
    keep = 20'((64'd1 << bits) - 1);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= (value & keep) | (20'($urandom) & ~keep);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    reg_val[idx] = value & keep;
  endtask

  task automatic set_timing(int low_t, int listen_t, int min_d, int max_d,
                            int min_w, int max_w, int tries, int gap);
    write_reg(REG_RESET_LOW, 20'(low_t));
    write_reg(REG_LISTEN, 20'(listen_t));
    write_reg(REG_MIN_DELAY, 20'(min_d));
    write_reg(REG_MAX_DELAY, 20'(max_d));
    write_reg(REG_MIN_WIDTH, 20'(min_w));
    write_reg(REG_MAX_WIDTH, 20'(max_w));
    write_reg(REG_ATTEMPTS, 20'(tries));
    write_reg(REG_RETRY_GAP, 20'(gap));
  endtask

  // Waits until every queued word has been sent and every result has come back.
  task automatic settle();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || cmd_valid || expected_res.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Queues one reset sequence shaped to the current timing, sometimes broken.
  task automatic add_sequence();
    cmd_t seq_q [$];
    int   r_len, win, tries, d, wd, lo, hi, cut;
    logic line_fault, lvl;
    r_len = (reg_val[REG_RESET_LOW] == 0) ? 1 : int'(reg_val[REG_RESET_LOW]);
    win = (reg_val[REG_LISTEN] == 0) ? 1 : int'(reg_val[REG_LISTEN]);
    tries = (reg_val[REG_ATTEMPTS] == 0) ? 1 : int'(reg_val[REG_ATTEMPTS]);
    seq_q.push_back(make_cmd(FUNC_START, 1'($urandom)));
    for (int a = 1; a <= tries; a++) begin
      // Idle check, now and then with the line stuck low.
      if ($urandom_range(0, 19) == 0) begin
        seq_q.push_back(make_cmd(FUNC_TICK, 1'b0));
        break;
      end
      seq_q.push_back(make_cmd(FUNC_TICK, 1'b1));
      // Reset pulse; only its last tick decides whether the low was seen.
      line_fault = ($urandom_range(0, 11) == 0);
      for (int i = 0; i < r_len; i++) begin
        lvl = (i == r_len - 1) ? line_fault : 1'($urandom_range(0, 7) == 0);
        seq_q.push_back(make_cmd(FUNC_TICK, lvl));
      end
      // Presence pulse with delay and width around the allowed bounds.
      lo = (reg_val[REG_MIN_DELAY] == 0) ? 0 : int'(reg_val[REG_MIN_DELAY]) - 1;
      hi = int'(reg_val[REG_MAX_DELAY]) + 1;
      if (hi > win - 1) hi = win - 1;
      d = (hi < lo || $urandom_range(0, 7) == 0) ? $urandom_range(0, win) :
          $urandom_range(lo, hi);
      lo = (reg_val[REG_MIN_WIDTH] == 0) ? 0 : int'(reg_val[REG_MIN_WIDTH]) - 1;
      hi = int'(reg_val[REG_MAX_WIDTH]) + 1;
      wd = (hi < lo || $urandom_range(0, 7) == 0) ? $urandom_range(0, win) :
           $urandom_range(lo, hi);
      for (int i = 0; i < win; i++) begin
        lvl = (i >= d && i < d + wd) ? 1'b0 : 1'b1;
        if ($urandom_range(0, 49) == 0) lvl = !lvl;
        seq_q.push_back(make_cmd(FUNC_TICK, lvl));
      end
      if (line_fault) break;
      if (a < tries) begin
        for (int i = 0; i < int'(reg_val[REG_RETRY_GAP]); i++)
          seq_q.push_back(make_cmd(FUNC_TICK, 1'($urandom)));
      end
    end
    // Cut some sequences short with an abort, and slip stray words into others.
    if ($urandom_range(0, 6) == 0) begin
      cut = $urandom_range(1, seq_q.size());
      seq_q = seq_q[0:cut-1];
      seq_q.push_back(make_cmd(FUNC_ABORT, 1'($urandom)));
    end
    if ($urandom_range(0, 7) == 0)
      seq_q.insert($urandom_range(1, seq_q.size()),
                   make_cmd(($urandom_range(0, 1) == 0) ? FUNC_START : FUNC_UNUSED,
                            1'($urandom)));
    foreach (seq_q[i]) pending_cmds.push_back(seq_q[i]);
    seq_items += seq_q.size();
  endtask

  // Mostly well-formed sequences with some noise, then an abort to leave the sequencer idle.
  task automatic run_random(int target);
    int start_count;
    int n;
    @(negedge clk);
    start_count = seq_items;
    while (seq_items - start_count < target) begin
      if ($urandom_range(0, 4) == 0) begin
        n = $urandom_range(1, 6);
        repeat (n)
          pending_cmds.push_back(make_cmd(2'($urandom), 1'($urandom)));
        seq_items += n;
      end else begin
        add_sequence();
      end
    end
    pending_cmds.push_back(make_cmd(FUNC_ABORT, 1'b0));
    settle();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed words with the reset timing: ignored words, stuck-low line, abort.
    pending_cmds.push_back(make_cmd(FUNC_TICK, 1'b0));
    pending_cmds.push_back(make_cmd(FUNC_TICK, 1'b1));
    pending_cmds.push_back(make_cmd(FUNC_ABORT, 1'b1));
    pending_cmds.push_back(make_cmd(FUNC_UNUSED, 1'b1));
    pending_cmds.push_back(make_cmd(FUNC_UNUSED, 1'b0));
    pending_cmds.push_back(make_cmd(FUNC_START, 1'b0));
    pending_cmds.push_back(make_cmd(FUNC_START, 1'b1));
    pending_cmds.push_back(make_cmd(FUNC_TICK, 1'b0));
    pending_cmds.push_back(make_cmd(FUNC_START, 1'b1));
    pending_cmds.push_back(make_cmd(FUNC_TICK, 1'b1));
    pending_cmds.push_back(make_cmd(FUNC_TICK, 1'b0));
    pending_cmds.push_back(make_cmd(FUNC_TICK, 1'b1));
    pending_cmds.push_back(make_cmd(FUNC_START, 1'b0));
    pending_cmds.push_back(make_cmd(FUNC_ABORT, 1'b0));
    pending_cmds.push_back(make_cmd(FUNC_ABORT, 1'b0));
    settle();

    // Zero in every register, then typical, wide-open and impossible bounds.
    set_timing(0, 0, 0, 0, 0, 0, 0, 0);
    run_random(40);
    set_timing(3, 40, 2, 10, 3, 12, 2, 4);
    run_random(90);
    set_timing(1, 12, 0, 1023, 0, 1023, 7, 0);
    run_random(90);
    set_timing(5, 30, 10, 5, 8, 4, 2, 1);
    run_random(60);

    // Every register at its maximum: one full attempt whose window fills with edges.
    quiet = 1'b1;
    set_timing(1023, 4095, 1023, 1023, 1023, 1023, 7, 1048575);
    @(negedge clk);
    pending_cmds.push_back(make_cmd(FUNC_START, 1'b1));
    pending_cmds.push_back(make_cmd(FUNC_TICK, 1'b1));
    repeat (1023) pending_cmds.push_back(make_cmd(FUNC_TICK, 1'b0));
    for (int i = 0; i < 80; i++) pending_cmds.push_back(make_cmd(FUNC_TICK, 1'(i % 2)));
    pending_cmds.push_back(make_cmd(FUNC_ABORT, 1'b1));
    settle();
    repeat (10) @(posedge clk);

    if (mismatches == 0 && expected_res.size() == 0) begin
      $display("onewire_reset_presence_detector_core: match");
    end else begin
      $display("onewire_reset_presence_detector_core: mismatch");
    end
    $finish;
  end

endmodule

[files.f]
src/ow_rpd_pkg.sv
src/onewire_reset_presence_detector_core.sv
test/tb_onewire_reset_presence_detector_core.sv
